@@ src/thc_pkg.sv @@
// Shared types, constants and the angle reduction used by the heading pipeline.
// No dependencies.
package thc_pkg;

	localparam int THC_CORDIC_STEPS = 16;
	localparam int THC_TAB_LEN = 24;
	localparam int THC_CW = 32;
	localparam int THC_ZW = 24;
	localparam int THC_VW = 36;
	localparam int THC_VZW = 26;
	localparam int THC_TURN = 46080;
	localparam int THC_HALF_INTERNAL = 180 * 32768;
	localparam logic signed [THC_CW-1:0] THC_GAIN = 32'sd652032874;

	localparam int THC_ATAN [THC_TAB_LEN] = '{
		1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
		7334, 3667, 1833, 917, 458, 229, 115, 57,
		29, 14, 7, 4, 2, 1, 0, 0
	};

	typedef struct packed {
		logic signed [THC_CW-1:0] x;
		logic signed [THC_CW-1:0] y;
		logic signed [THC_ZW-1:0] z;
		logic                     neg;
	} rot_t;

	typedef struct packed {
		logic signed [THC_VW-1:0]  x;
		logic signed [THC_VW-1:0]  y;
		logic signed [THC_VZW-1:0] z;
		logic                      zero;
	} vec_t;

	function automatic rot_t thc_rot_init(input logic signed [15:0] ang);
		logic signed [17:0] a;
		rot_t r;
		a = 18'(ang);
		r.neg = 1'b0;
		if (a > 18'sd23040) begin
			a = a - 18'sd46080;
		end else if (a < -18'sd23040) begin
			a = a + 18'sd46080;
		end
		if (a > 18'sd11520) begin
			a = a - 18'sd23040;
			r.neg = 1'b1;
		end else if (a < -18'sd11520) begin
			a = a + 18'sd23040;
			r.neg = 1'b1;
		end
		r.x = THC_GAIN;
		r.y = '0;
		r.z = THC_ZW'(a) <<< 8;
		return r;
	endfunction

endpackage

@@ src/thc_if.sv @@
// Handshake interfaces for the sample and heading channels.
// Depends on nothing.
interface thc_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] mag_x;
	logic signed [15:0] mag_y;
	logic signed [15:0] mag_z;
	logic signed [15:0] pitch_angle;
	logic signed [15:0] roll_angle;
	modport source(output valid, mag_x, mag_y, mag_z, pitch_angle, roll_angle, input ready);
	modport sink(input valid, mag_x, mag_y, mag_z, pitch_angle, roll_angle, output ready);
endinterface

interface thc_heading_if;
	logic        valid;
	logic        ready;
	logic [15:0] heading;
	modport source(output valid, heading, input ready);
	modport sink(input valid, heading, output ready);
endinterface

@@ src/thc_rot_cell.sv @@
// One CORDIC rotation step: sine and cosine from an angle.
// Depends on thc_pkg.
module thc_rot_cell import thc_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic clk,
	input  logic adv,
	input  rot_t d,
	output rot_t q
);
	localparam logic signed [THC_ZW-1:0] ATAN = THC_ZW'(THC_ATAN[STEP]);
	rot_t nxt;

	always_comb begin
		nxt.neg = d.neg;
		if (d.z >= 0) begin
			nxt.x = d.x - (d.y >>> STEP);
			nxt.y = d.y + (d.x >>> STEP);
			nxt.z = d.z - ATAN;
		end else begin
			nxt.x = d.x + (d.y >>> STEP);
			nxt.y = d.y - (d.x >>> STEP);
			nxt.z = d.z + ATAN;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q <= nxt;
		end
	end
endmodule

@@ src/thc_vec_cell.sv @@
// One CORDIC vectoring step: accumulates the angle of (x, y).
// Depends on thc_pkg.
module thc_vec_cell import thc_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic clk,
	input  logic adv,
	input  vec_t d,
	output vec_t q
);
	localparam logic signed [THC_VZW-1:0] ATAN = THC_VZW'(THC_ATAN[STEP]);
	vec_t nxt;

	always_comb begin
		nxt.zero = d.zero;
		if (d.y >= 0) begin
			nxt.x = d.x + (d.y >>> STEP);
			nxt.y = d.y - (d.x >>> STEP);
			nxt.z = d.z + ATAN;
		end else begin
			nxt.x = d.x - (d.y >>> STEP);
			nxt.y = d.y + (d.x >>> STEP);
			nxt.z = d.z - ATAN;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q <= nxt;
		end
	end
endmodule

@@ src/thc_proj.sv @@
// Three-stage tilt projection of the field onto the horizontal plane.
// Depends on thc_pkg.
module thc_proj import thc_pkg::*; (
	input  logic                     clk,
	input  logic                     adv,
	input  logic signed [15:0]       mag_x,
	input  logic signed [15:0]       mag_y,
	input  logic signed [15:0]       mag_z,
	input  rot_t                     pa,
	input  rot_t                     ro,
	output logic signed [THC_VW-1:0] xh,
	output logic signed [THC_VW-1:0] yh
);
	logic signed [THC_CW-1:0] sa, ca, sb, cb;
	logic signed [47:0] a1_s1, a2_s1, a3_s1, a4_s1, a5_s1;
	logic signed [THC_CW-1:0] sb_s1;
	logic signed [THC_CW-1:0] u, v;
	logic signed [THC_VW-1:0] t1_s2, yh_s2;
	logic signed [63:0] m1_s2, m2_s2;
	logic signed [48:0] ysum;

	always_comb begin
		ca = pa.neg ? -pa.x : pa.x;
		sa = pa.neg ? -pa.y : pa.y;
		cb = ro.neg ? -ro.x : ro.x;
		sb = ro.neg ? -ro.y : ro.y;
		u = THC_CW'(a2_s1 >>> 15);
		v = THC_CW'(a3_s1 >>> 15);
		ysum = 49'(a4_s1) + 49'(a5_s1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a1_s1 <= 48'(mag_x) * 48'(cb);
			a2_s1 <= 48'(mag_y) * 48'(sa);
			a3_s1 <= 48'(mag_z) * 48'(ca);
			a4_s1 <= 48'(mag_y) * 48'(ca);
			a5_s1 <= 48'(mag_z) * 48'(sa);
			sb_s1 <= sb;
			t1_s2 <= THC_VW'(a1_s1 >>> 15);
			m1_s2 <= 64'(u) * 64'(sb_s1);
			m2_s2 <= 64'(v) * 64'(sb_s1);
			yh_s2 <= THC_VW'(ysum >>> 15);
			xh <= t1_s2 + THC_VW'(m1_s2 >>> 30) - THC_VW'(m2_s2 >>> 30);
			yh <= yh_s2;
		end
	end
endmodule

@@ src/tilt_compensated_heading.sv @@
// Channel   Dir  Payload
// sample    in   mag_x, mag_y, mag_z, pitch_angle, roll_angle
// result    out  heading
// cfg       in   cfg_we, cfg_wdata (declination)
// N = min(CORDIC_STEPS, 24); one transaction per cycle while the result is not stalled.
// Samples pass through the rotation cells, three projection stages, the vectoring cells and the output register.
// The whole pipeline holds while the result is stalled; ready follows the output register.
// arst_n clears the valid pipeline and the declination register.
module tilt_compensated_heading import thc_pkg::*; #(
	parameter int CORDIC_STEPS = THC_CORDIC_STEPS
) (
	input  logic               clk,
	input  logic               arst_n,
	thc_sample_if.sink         sample,
	thc_heading_if.source      result,
	input  logic               cfg_we,
	input  logic signed [15:0] cfg_wdata
);
	localparam int N = (CORDIC_STEPS > THC_TAB_LEN) ? THC_TAB_LEN : CORDIC_STEPS;
	localparam int LAT = 2 * N + 4;

	logic adv;
	logic [LAT-1:0] valid_q;
	logic signed [15:0] decl_q;
	logic [15:0] heading_q;
	rot_t pa [0:N];
	rot_t ro [0:N];
	vec_t vc [0:N];
	logic signed [15:0] mx_p [0:N];
	logic signed [15:0] my_p [0:N];
	logic signed [15:0] mz_p [0:N];
	logic signed [THC_VW-1:0] xh, yh;
	logic signed [THC_VZW-1:0] zr;
	logic signed [18:0] hsum, hwrap;

	assign adv = !valid_q[LAT-1] || result.ready;
	assign sample.ready = adv;
	assign result.valid = valid_q[LAT-1];
	assign result.heading = heading_q;

	assign pa[0] = thc_rot_init(sample.pitch_angle);
	assign ro[0] = thc_rot_init(sample.roll_angle);
	assign mx_p[0] = sample.mag_x;
	assign my_p[0] = sample.mag_y;
	assign mz_p[0] = sample.mag_z;

	for (genvar i = 0; i < N; i++) begin : g_rot
		thc_rot_cell #(.STEP(i)) u_pa (.clk(clk), .adv(adv), .d(pa[i]), .q(pa[i+1]));
		thc_rot_cell #(.STEP(i)) u_ro (.clk(clk), .adv(adv), .d(ro[i]), .q(ro[i+1]));
		always_ff @(posedge clk) begin
			if (adv) begin
				mx_p[i+1] <= mx_p[i];
				my_p[i+1] <= my_p[i];
				mz_p[i+1] <= mz_p[i];
			end
		end
	end

	thc_proj u_proj (
		.clk(clk), .adv(adv),
		.mag_x(mx_p[N]), .mag_y(my_p[N]), .mag_z(mz_p[N]),
		.pa(pa[N]), .ro(ro[N]),
		.xh(xh), .yh(yh)
	);

	always_comb begin
		vc[0].zero = (xh == 0) && (yh == 0);
		if (xh < 0) begin
			vc[0].x = -xh;
			vc[0].y = -yh;
			vc[0].z = THC_VZW'(THC_HALF_INTERNAL);
		end else begin
			vc[0].x = xh;
			vc[0].y = yh;
			vc[0].z = '0;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_vec
		thc_vec_cell #(.STEP(i)) u_vec (.clk(clk), .adv(adv), .d(vc[i]), .q(vc[i+1]));
	end

	always_comb begin
		if (vc[N].zero) begin
			zr = '0;
		end else begin
			zr = (vc[N].z + THC_VZW'(128)) >>> 8;
		end
		hsum = 19'(zr) + 19'(decl_q);
		if (hsum < 0) begin
			hwrap = hsum + 19'(THC_TURN);
		end else if (hsum >= 19'(THC_TURN)) begin
			hwrap = hsum - 19'(THC_TURN);
		end else begin
			hwrap = hsum;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			heading_q <= hwrap[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			decl_q <= '0;
		end else begin
			if (adv) begin
				valid_q <= {valid_q[LAT-2:0], sample.valid};
			end
			if (cfg_we) begin
				decl_q <= cfg_wdata;
			end
		end
	end

`ifndef SYNTHESIS
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.heading < 16'(THC_TURN))
		else $error("heading out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(result.heading))
		else $error("stalled result changed");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q == '0 |=> !result.valid)
		else $error("result from empty pipeline");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> sample.ready)
		else $error("input blocked with free output");
`endif
endmodule
